### rtl/core/bscpu_pkg.sv
// Package: opcodes and shared types of the teaching CPU execute block.
package bscpu_pkg;

    localparam int unsigned RF_DEPTH = 16;
    localparam int unsigned RF_AW    = 4;
    localparam int unsigned DW       = 8;

    // Opcode nibble values.
    localparam logic [3:0] OP_NOP      = 4'h0;
    localparam logic [3:0] OP_LOAD_MEM = 4'h1;
    localparam logic [3:0] OP_LOAD_IMM = 4'h2;
    localparam logic [3:0] OP_STORE    = 4'h3;
    localparam logic [3:0] OP_MOVE     = 4'h4;
    localparam logic [3:0] OP_ADD      = 4'h5;
    localparam logic [3:0] OP_FADD     = 4'h6;
    localparam logic [3:0] OP_OR       = 4'h7;
    localparam logic [3:0] OP_AND      = 4'h8;
    localparam logic [3:0] OP_XOR      = 4'h9;
    localparam logic [3:0] OP_ROR      = 4'hA;
    localparam logic [3:0] OP_JMP_EQ   = 4'hB;
    localparam logic [3:0] OP_HALT     = 4'hC;
    localparam logic [3:0] OP_LOAD_IND = 4'hD;
    localparam logic [3:0] OP_STOR_IND = 4'hE;
    localparam logic [3:0] OP_JMP_LE   = 4'hF;

    // Register zero is the comparison operand of both conditional jumps.
    localparam logic [RF_AW-1:0] REG_CMP = 4'h0;
    // Register fifteen is the output port.
    localparam logic [RF_AW-1:0] REG_OUT = 4'hF;

    // Register file write request.
    typedef struct packed {
        logic             en;
        logic [RF_AW-1:0] addr;
        logic [DW-1:0]    data;
    } rf_wr_t;

endpackage

### rtl/core/bscpu_regfile.sv
// Register file: 16 bytes, two synchronous read ports, one write port, write-first.
module bscpu_regfile (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [bscpu_pkg::RF_AW-1:0]   rd_addr_a,
    input  logic [bscpu_pkg::RF_AW-1:0]   rd_addr_b,
    output logic [bscpu_pkg::DW-1:0]      rd_data_a,
    output logic [bscpu_pkg::DW-1:0]      rd_data_b,
    input  bscpu_pkg::rf_wr_t             wr
);

    logic [bscpu_pkg::DW-1:0]       mem [bscpu_pkg::RF_DEPTH];
    logic [bscpu_pkg::RF_DEPTH-1:0] vld_reg;
    logic [bscpu_pkg::DW-1:0]       data_a_reg;
    logic [bscpu_pkg::DW-1:0]       data_b_reg;
    logic                           zero_a_reg;
    logic                           zero_b_reg;
    logic                           hit_a;
    logic                           hit_b;

    assign hit_a = wr.en && (wr.addr == rd_addr_a);
    assign hit_b = wr.en && (wr.addr == rd_addr_b);

    // An entry never written since reset reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr.en) begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // A read at the edge of a write to the same entry returns the new data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            data_a_reg <= hit_a ? wr.data : mem[rd_addr_a];
            data_b_reg <= hit_b ? wr.data : mem[rd_addr_b];
            zero_a_reg <= !hit_a && !vld_reg[rd_addr_a];
            zero_b_reg <= !hit_b && !vld_reg[rd_addr_b];
        end
    end

    assign rd_data_a = zero_a_reg ? '0 : data_a_reg;
    assign rd_data_b = zero_b_reg ? '0 : data_b_reg;

endmodule

### rtl/core/eight_bit_teaching_cpu_execute.sv
// Top level: execute unit of an 8-bit teaching CPU, one instruction per transfer.
//
// The s_ channel takes one instruction per transfer as four nibbles: s_op, s_reg_a,
// s_nib_x and s_nib_y. The m_ channel returns one result per instruction: the next
// program address, a halt flag and the value of register 15 (the output port).
// Each instruction moves through two stages. At the input transfer the register
// file (a two-port synchronous memory) is read. In stage one the ALU and
// jump logic run, the program address is updated and the data memory is read or
// written. In stage two a loaded or computed byte is written back and the
// result is loaded into the output register, which drives m_valid.
// A new instruction is taken only after the previous one has left stage one: the
// register-indirect load reads the register file and then the data memory, and
// the next instruction's register reads must line up with the previous write-back,
// which the register file forwards at the same edge.
// Reset clears the program address and the valid bits of the register file and of
// the data memory, so every register and every byte reads as zero until written;
// there is no clearing pass. When the receiver stalls, the result waits in the
// output register, one more instruction may finish into the second stage, and
// s_ready then stays low until the output register drains.
module eight_bit_teaching_cpu_execute #(
    parameter int unsigned MEM_DEPTH = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [3:0]        s_op,
    input  logic [3:0]        s_reg_a,
    input  logic [3:0]        s_nib_x,
    input  logic [3:0]        s_nib_y,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_next_address,
    output logic              m_halted,
    output logic signed [7:0] m_out_value
);

    localparam int unsigned ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // Byte address to memory index, folded modulo the memory depth.
    logic [ADDR_W-1:0] idx_tbl [256];
    for (genvar gi = 0; gi < 256; gi++) begin : g_idx
        assign idx_tbl[gi] = ADDR_W'(gi % MEM_DEPTH);
    end

    // Pipeline control.
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic m_valid_reg;
    logic s2_go;
    logic accept;

    // Stage one: decoded instruction, register data arrives from the register file.
    logic [3:0] s1_op_reg;
    logic [3:0] s1_ra_reg;
    logic [3:0] s1_nx_reg;
    logic [3:0] s1_ny_reg;

    // Stage two: write-back and result fields.
    logic                    s2_wr_en_reg;
    logic [3:0]              s2_wr_addr_reg;
    logic [7:0]              s2_alu_reg;
    logic                    s2_load_reg;
    logic                    s2_halt_reg;
    logic [7:0]              s2_next_reg;

    // Architectural program address and output port shadow.
    logic [7:0] pc_reg;
    logic [7:0] r15_reg;

    // Output register.
    logic [7:0] out_addr_reg;
    logic       out_halt_reg;
    logic [7:0] out_val_reg;

    // Register file ports.
    logic [3:0]        rd_addr_a;
    logic [3:0]        rd_addr_b;
    logic [7:0]        val_a;
    logic [7:0]        val_b;
    bscpu_pkg::rf_wr_t rf_wr;

    // Data memory.
    logic [7:0]           dmem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] dvld_reg;
    logic [7:0]           dm_rd_reg;
    logic                 dm_vld_rd_reg;
    logic [7:0]           dm_data;

    // Stage one combinational results.
    logic [7:0]        xy;
    logic [7:0]        pc_next;
    logic [7:0]        alu;
    logic [15:0]       rot_w;
    logic              wr_en;
    logic [3:0]        wr_addr;
    logic              is_load;
    logic              is_store;
    logic [ADDR_W-1:0] mem_idx;
    logic [7:0]        wb_data;

    assign s2_go   = !m_valid_reg || m_ready;
    // Take an instruction only when stage two will not write back later than
    // this instruction's register read.
    assign s_ready = !s1_valid_reg && (!s2_valid_reg || s2_go);
    assign accept  = s_valid && s_ready;

    // Read-port selection by opcode.
    always_comb begin
        rd_addr_a = s_reg_a;
        rd_addr_b = s_nib_y;
        case (s_op)
            bscpu_pkg::OP_MOVE,
            bscpu_pkg::OP_ADD,
            bscpu_pkg::OP_OR,
            bscpu_pkg::OP_AND,
            bscpu_pkg::OP_XOR,
            bscpu_pkg::OP_STOR_IND: rd_addr_a = s_nib_x;
            bscpu_pkg::OP_JMP_EQ,
            bscpu_pkg::OP_JMP_LE:   rd_addr_b = bscpu_pkg::REG_CMP;
            default:                rd_addr_a = s_reg_a;
        endcase
    end

    bscpu_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (accept),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (val_a),
        .rd_data_b (val_b),
        .wr        (rf_wr)
    );

    // Stage one: execute.
    assign xy    = {s1_nx_reg, s1_ny_reg};
    assign rot_w = {val_a, val_a} >> s1_ny_reg[2:0];

    always_comb begin
        pc_next  = 8'(pc_reg + 8'd2);
        alu      = val_a;
        wr_en    = 1'b0;
        wr_addr  = s1_ra_reg;
        is_load  = 1'b0;
        is_store = 1'b0;
        mem_idx  = idx_tbl[xy];
        case (s1_op_reg)
            bscpu_pkg::OP_LOAD_MEM: begin
                wr_en   = 1'b1;
                is_load = 1'b1;
            end
            bscpu_pkg::OP_LOAD_IMM: begin
                wr_en = 1'b1;
                alu   = xy;
            end
            bscpu_pkg::OP_STORE: is_store = 1'b1;
            bscpu_pkg::OP_MOVE: begin
                wr_en   = 1'b1;
                wr_addr = s1_ny_reg;
            end
            bscpu_pkg::OP_ADD: begin
                wr_en = 1'b1;
                alu   = 8'(val_a + val_b);
            end
            bscpu_pkg::OP_OR: begin
                wr_en = 1'b1;
                alu   = val_a | val_b;
            end
            bscpu_pkg::OP_AND: begin
                wr_en = 1'b1;
                alu   = val_a & val_b;
            end
            bscpu_pkg::OP_XOR: begin
                wr_en = 1'b1;
                alu   = val_a ^ val_b;
            end
            bscpu_pkg::OP_ROR: begin
                wr_en = 1'b1;
                alu   = rot_w[7:0];
            end
            bscpu_pkg::OP_JMP_EQ: begin
                if (val_a == val_b) begin
                    pc_next = xy;
                end
            end
            bscpu_pkg::OP_JMP_LE: begin
                if ($signed(val_a) <= $signed(val_b)) begin
                    pc_next = xy;
                end
            end
            bscpu_pkg::OP_LOAD_IND: begin
                wr_en   = 1'b1;
                wr_addr = s1_nx_reg;
                is_load = 1'b1;
                mem_idx = idx_tbl[val_b];
            end
            bscpu_pkg::OP_STOR_IND: begin
                is_store = 1'b1;
                mem_idx  = idx_tbl[val_b];
            end
            default: wr_en = 1'b0;
        endcase
    end

    // Data memory: valid bits make every byte read as zero until it is written.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dvld_reg <= '0;
        end else if (s1_valid_reg && is_store) begin
            dvld_reg[mem_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && is_store) begin
            dmem[mem_idx] <= val_a;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && is_load) begin
            dm_rd_reg     <= dmem[mem_idx];
            dm_vld_rd_reg <= dvld_reg[mem_idx];
        end
    end

    assign dm_data = dm_vld_rd_reg ? dm_rd_reg : 8'd0;

    // Stage two: write-back.
    assign wb_data    = s2_load_reg ? dm_data : s2_alu_reg;
    assign rf_wr.en   = s2_valid_reg && s2_go && s2_wr_en_reg;
    assign rf_wr.addr = s2_wr_addr_reg;
    assign rf_wr.data = wb_data;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            pc_reg       <= 8'd0;
            r15_reg      <= 8'd0;
        end else begin
            s1_valid_reg <= accept;
            if (s1_valid_reg) begin
                s2_valid_reg <= 1'b1;
                pc_reg       <= pc_next;
            end else if (s2_go) begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_valid_reg && s2_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (rf_wr.en && (rf_wr.addr == bscpu_pkg::REG_OUT)) begin
                r15_reg <= wb_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_op_reg <= s_op;
            s1_ra_reg <= s_reg_a;
            s1_nx_reg <= s_nib_x;
            s1_ny_reg <= s_nib_y;
        end
        if (s1_valid_reg) begin
            s2_wr_en_reg   <= wr_en;
            s2_wr_addr_reg <= wr_addr;
            s2_alu_reg     <= alu;
            s2_load_reg    <= is_load;
            s2_halt_reg    <= (s1_op_reg == bscpu_pkg::OP_HALT);
            s2_next_reg    <= pc_next;
        end
        if (s2_valid_reg && s2_go) begin
            out_addr_reg <= s2_next_reg;
            out_halt_reg <= s2_halt_reg;
            out_val_reg  <= (rf_wr.en && (rf_wr.addr == bscpu_pkg::REG_OUT)) ?
                            wb_data : r15_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_next_address = out_addr_reg;
    assign m_halted       = out_halt_reg;
    assign m_out_value    = $signed(out_val_reg);

endmodule
